/* hdl/xyls_pkg.sv */
package xyls_pkg;

	localparam int CAPACITY   = 32;
	localparam int COORD_BITS = 16;
	localparam int TAG_BITS   = 6;

	typedef struct packed {
		logic                  valid;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [TAG_BITS-1:0]   tag;
	} rec_t;

	// ins: insert the broadcast record; shl: shift the chain toward cell 0
	typedef struct packed {
		logic ins;
		logic shl;
	} ctl_t;

	typedef enum logic {
		ST_FILL,
		ST_EMIT
	} state_t;

endpackage

/* hdl/xyls_cell.sv */
module xyls_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  xyls_pkg::ctl_t  ctl,
	input  xyls_pkg::rec_t  new_rec,
	input  xyls_pkg::rec_t  prev_rec,
	input  logic            prev_p,
	input  xyls_pkg::rec_t  next_rec,
	output xyls_pkg::rec_t  rec,
	output logic            p
);

	logic                            valid_q;
	logic [xyls_pkg::COORD_BITS-1:0] x_q;
	logic [xyls_pkg::COORD_BITS-1:0] y_q;
	logic [xyls_pkg::TAG_BITS-1:0]   tag_q;
	xyls_pkg::rec_t                  nxt;

	// p: this slot is empty or holds a key strictly greater than the new one
	always_comb begin
		p = !valid_q || (x_q > new_rec.x) || ((x_q == new_rec.x) && (y_q > new_rec.y));
	end

	always_comb begin
		nxt = '{valid: valid_q, x: x_q, y: y_q, tag: tag_q};
		if (ctl.shl) begin
			nxt = next_rec;
		end else if (ctl.ins && p) begin
			if (prev_p) begin
				nxt = prev_rec;
			end else begin
				nxt = new_rec;
				nxt.valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		x_q   <= nxt.x;
		y_q   <= nxt.y;
		tag_q <= nxt.tag;
	end

	assign rec = '{valid: valid_q, x: x_q, y: y_q, tag: tag_q};

endmodule

/* hdl/xy_lexicographic_sorter.sv */
// Channel  | Valid      | Stall      | Payload
// input    | obj_valid  | obj_stall  | obj_x, obj_y, obj_tag, run_end
// output   | res_valid  | res_stall  | out_x, out_y, out_tag, out_last, overflowed
//
// Insertion: one record per cycle while filling; CAPACITY compare-and-shift cells place
// each record in its sorted slot. A record arriving with the store full is dropped.
// Emission: after run_end the chain shifts toward cell 0, one record per cycle
// through the output register unless res_stall holds it; obj_stall is high throughout.
// Reset clears the cell valid bits, the overflow flag and the output valid.
module xy_lexicographic_sorter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            obj_valid,
	output logic                            obj_stall,
	input  logic [xyls_pkg::COORD_BITS-1:0] obj_x,
	input  logic [xyls_pkg::COORD_BITS-1:0] obj_y,
	input  logic [xyls_pkg::TAG_BITS-1:0]   obj_tag,
	input  logic                            run_end,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [xyls_pkg::COORD_BITS-1:0] out_x,
	output logic [xyls_pkg::COORD_BITS-1:0] out_y,
	output logic [xyls_pkg::TAG_BITS-1:0]   out_tag,
	output logic                            out_last,
	output logic                            overflowed
);

	xyls_pkg::state_t state_q, state_nxt;
	xyls_pkg::ctl_t   ctl;
	xyls_pkg::rec_t   new_rec;
	xyls_pkg::rec_t   chain [xyls_pkg::CAPACITY];
	logic             p     [xyls_pkg::CAPACITY];
	logic             obj_acc;
	logic             full;
	logic             load;
	logic             ovf_q;
	logic             res_valid_q;

	assign new_rec = '{valid: 1'b1, x: obj_x, y: obj_y, tag: obj_tag};
	assign full    = chain[xyls_pkg::CAPACITY-1].valid;
	assign obj_acc = obj_valid && !obj_stall;

	genvar gi;
	generate
		for (gi = 0; gi < xyls_pkg::CAPACITY; gi++) begin : g_cell
			xyls_pkg::rec_t prev_rec;
			xyls_pkg::rec_t next_rec;
			logic           prev_p;
			if (gi == 0) begin : g_head
				assign prev_rec = '0;
				assign prev_p   = 1'b0;
			end else begin : g_mid
				assign prev_rec = chain[gi-1];
				assign prev_p   = p[gi-1];
			end
			if (gi == xyls_pkg::CAPACITY-1) begin : g_tail
				assign next_rec = '0;
			end else begin : g_body
				assign next_rec = chain[gi+1];
			end
			xyls_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.new_rec  (new_rec),
				.prev_rec (prev_rec),
				.prev_p   (prev_p),
				.next_rec (next_rec),
				.rec      (chain[gi]),
				.p        (p[gi])
			);
		end
	endgenerate

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			xyls_pkg::ST_FILL: begin
				if (obj_acc && run_end) begin
					state_nxt = xyls_pkg::ST_EMIT;
				end
			end
			xyls_pkg::ST_EMIT: begin
				if (load && !chain[1].valid) begin
					state_nxt = xyls_pkg::ST_FILL;
				end
			end
			default: state_nxt = xyls_pkg::ST_FILL;
		endcase
	end

	always_comb begin
		obj_stall = 1'b0;
		load      = 1'b0;
		ctl       = '0;
		unique case (state_q)
			xyls_pkg::ST_FILL: begin
				ctl.ins = obj_valid && !full;
			end
			xyls_pkg::ST_EMIT: begin
				obj_stall = 1'b1;
				load      = !res_valid_q || !res_stall;
				ctl.shl   = load;
			end
			default: obj_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xyls_pkg::ST_FILL;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (obj_acc && full) begin
				ovf_q <= 1'b1;
			end else if (load && !chain[1].valid) begin
				ovf_q <= 1'b0;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_x      <= chain[0].x;
			out_y      <= chain[0].y;
			out_tag    <= chain[0].tag;
			out_last   <= !chain[1].valid;
			overflowed <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;

endmodule

/* hdl/xyls_checker.sv */
module xyls_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            obj_valid,
	input logic                            obj_stall,
	input logic                            run_end,
	input logic                            res_valid,
	input logic                            res_stall,
	input logic [xyls_pkg::COORD_BITS-1:0] out_x,
	input logic [xyls_pkg::TAG_BITS-1:0]   out_tag,
	input logic                            out_last,
	input logic                            overflowed
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_x) && $stable(out_tag)
			&& $stable(out_last))
		else $error("stalled result changed");

	a_run_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		obj_valid && !obj_stall && run_end |=> obj_stall)
		else $error("input not stalled after run end");

	a_emit_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_last |-> obj_stall)
		else $error("input open during emission");

	a_ovf_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !out_last |=> !res_valid || overflowed == $past(overflowed))
		else $error("overflow flag changed within a run");

endmodule

bind xy_lexicographic_sorter xyls_checker u_xyls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.obj_valid  (obj_valid),
	.obj_stall  (obj_stall),
	.run_end    (run_end),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.out_x      (out_x),
	.out_tag    (out_tag),
	.out_last   (out_last),
	.overflowed (overflowed)
);

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int IDLE_LIMIT = 2000;
	localparam int ITEM_TARGET = 460;
	localparam int SETTLE_CYCLES = 16;

	typedef logic [xyls_pkg::COORD_BITS-1:0] coord_t;
	typedef logic [xyls_pkg::TAG_BITS-1:0] tag_t;

	typedef struct {
		coord_t x;
		coord_t y;
		tag_t   tag;
		logic   last;
		logic   ovf;
	} sorted_rec_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   obj_valid;
	logic   obj_stall;
	coord_t obj_x;
	coord_t obj_y;
	tag_t   obj_tag;
	logic   run_end;
	logic   res_valid;
	logic   res_stall;
	coord_t out_x;
	coord_t out_y;
	tag_t   out_tag;
	logic   out_last;
	logic   overflowed;

	// sorted-store model
	coord_t      store_x[xyls_pkg::CAPACITY];
	coord_t      store_y[xyls_pkg::CAPACITY];
	tag_t        store_tag[xyls_pkg::CAPACITY];
	int          store_fill;
	bit          store_ovf;
	sorted_rec_t sorted_q[$];
	sorted_rec_t head_rec;

	int errors;
	int items_sent;
	int idle_cycles;
	int in_gap_max;
	int out_gap_max;

	xy_lexicographic_sorter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.obj_valid  (obj_valid),
		.obj_stall  (obj_stall),
		.obj_x      (obj_x),
		.obj_y      (obj_y),
		.obj_tag    (obj_tag),
		.run_end    (run_end),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_tag    (out_tag),
		.out_last   (out_last),
		.overflowed (overflowed)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// stable insert: new record goes after every stored record with an equal key
	task automatic sort_insert(input coord_t x, input coord_t y, input tag_t tag,
			input logic last);
		int pos;
		sorted_rec_t rec;
		pos = 0;
		if (store_fill >= xyls_pkg::CAPACITY) begin
			store_ovf = 1'b1;
		end else begin
			while (pos < store_fill && !(store_x[pos] > x ||
					(store_x[pos] == x && store_y[pos] > y)))
				pos++;
			for (int k = store_fill; k > pos; k--) begin
				store_x[k]   = store_x[k-1];
				store_y[k]   = store_y[k-1];
				store_tag[k] = store_tag[k-1];
			end
			store_x[pos]   = x;
			store_y[pos]   = y;
			store_tag[pos] = tag;
			store_fill++;
		end
		if (last) begin
			for (int k = 0; k < store_fill; k++) begin
				rec.x    = store_x[k];
				rec.y    = store_y[k];
				rec.tag  = store_tag[k];
				rec.last = (k == store_fill - 1);
				rec.ovf  = store_ovf;
				sorted_q.push_back(rec);
			end
			store_fill = 0;
			store_ovf  = 1'b0;
		end
	endtask

	task automatic send_obj(input coord_t x, input coord_t y, input tag_t tag,
			input logic last);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap != 0) begin
			obj_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		obj_valid <= 1'b1;
		obj_x     <= x;
		obj_y     <= y;
		obj_tag   <= tag;
		run_end   <= last;
		do @(posedge clk); while (obj_stall);
		sort_insert(x, y, tag, last);
		items_sent++;
	endtask

	function automatic coord_t pick_coord(input int spread);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return coord_t'($urandom_range(0, spread));
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic send_run(input int len, input int spread);
		for (int i = 0; i < len; i++)
			send_obj(pick_coord(spread), pick_coord(spread),
				tag_t'($urandom_range(0, 63)), i == len - 1);
	endtask

	task automatic wait_drain();
		obj_valid <= 1'b0;
		while (sorted_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		send_obj('0, '0, '0, 1'b1);
		send_obj('1, '1, '1, 1'b1);
		// mixed keys, one duplicate key kept in arrival order
		send_obj(16'd5, 16'd9, 6'd1, 1'b0);
		send_obj(16'd5, 16'd2, 6'd2, 1'b0);
		send_obj(16'd1, 16'hFFFF, 6'd3, 1'b0);
		send_obj(16'hFFFF, 16'd0, 6'd4, 1'b0);
		send_obj(16'd5, 16'd9, 6'd5, 1'b0);
		send_obj(16'd0, 16'd0, 6'd6, 1'b1);
		// all keys equal
		for (int i = 0; i < 4; i++)
			send_obj(16'd7, 16'd7, tag_t'(10 + i), i == 3);
		// descending x
		for (int i = 0; i < 4; i++)
			send_obj(coord_t'(3 - i), 16'd0, tag_t'(20 + i), i == 3);
		// equal x, descending y
		for (int i = 0; i < 3; i++)
			send_obj(16'd9, coord_t'(3 - i), tag_t'(30 + i), i == 2);
	endtask

	task automatic test_overflow();
		send_run(xyls_pkg::CAPACITY, 3);
		// run_end record itself dropped
		send_run(xyls_pkg::CAPACITY + 1, 7);
		send_run(xyls_pkg::CAPACITY + 5, 65535);
		// flag must be clear again
		send_run(1, 3);
	endtask

	task automatic test_back_to_back();
		in_gap_max  = 0;
		out_gap_max = 0;
		send_run(12, 3);
		send_run(1, 3);
		send_run(20, 65535);
		send_run(6, 1);
		in_gap_max  = 12;
		out_gap_max = 12;
	endtask

	task automatic test_drain_pause();
		send_run(10, 3);
		wait_drain();
		send_run(5, 65535);
	endtask

	task automatic test_random_runs();
		int len;
		int sel;
		while (items_sent < ITEM_TARGET) begin
			sel = $urandom_range(0, 9);
			if (sel < 7)
				len = $urandom_range(1, 8);
			else if (sel < 9)
				len = $urandom_range(9, xyls_pkg::CAPACITY - 1);
			else
				len = $urandom_range(xyls_pkg::CAPACITY, xyls_pkg::CAPACITY + 8);
			in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 12;
			out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			send_run(len, ($urandom_range(0, 1) == 1) ? 3 : 255);
		end
		in_gap_max  = 12;
		out_gap_max = 12;
	endtask

	initial begin
		arst_n      = 1'b0;
		obj_valid   = 1'b0;
		obj_x       = '0;
		obj_y       = '0;
		obj_tag     = '0;
		run_end     = 1'b0;
		errors      = 0;
		items_sent  = 0;
		store_fill  = 0;
		store_ovf   = 1'b0;
		in_gap_max  = 12;
		out_gap_max = 12;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_overflow();
		test_back_to_back();
		test_drain_pause();
		test_random_runs();

		obj_valid <= 1'b0;
		while (sorted_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && sorted_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		int hold;
		res_stall = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			hold = $urandom_range(0, out_gap_max);
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!(res_valid && !res_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (sorted_q.size() == 0) begin
				report_mismatch("unexpected transaction, out_x", 32'(out_x), 32'd0);
			end else begin
				head_rec = sorted_q.pop_front();
				if (out_x !== head_rec.x)
					report_mismatch("out_x", 32'(out_x), 32'(head_rec.x));
				if (out_y !== head_rec.y)
					report_mismatch("out_y", 32'(out_y), 32'(head_rec.y));
				if (out_tag !== head_rec.tag)
					report_mismatch("out_tag", 32'(out_tag), 32'(head_rec.tag));
				if (out_last !== head_rec.last)
					report_mismatch("out_last", 32'(out_last), 32'(head_rec.last));
				if (overflowed !== head_rec.ovf)
					report_mismatch("overflowed", 32'(overflowed), 32'(head_rec.ovf));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((obj_valid && !obj_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
